@@ rtl/sjf_pkg.sv @@
// ----------------------------------------------------------------------------
// sjf_pkg
// Shared widths, limits and job record type for the job scheduler.
// ----------------------------------------------------------------------------
package sjf_pkg;

   localparam int MAX_JOBS = 512;
   localparam int IDX_W    = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
   localparam int CNT_W    = $clog2(MAX_JOBS + 1);

   localparam int ARR_W    = 16;
   localparam int RUN_W    = 16;
   localparam int TIME_W   = 26;
   localparam int TOT_W    = 35;
   localparam int MEAN_W   = 26;

   localparam int QDEPTH   = 4;
   localparam int QPTR_W   = $clog2(QDEPTH);

   typedef struct packed {
      logic [ARR_W-1:0] arrival;
      logic [RUN_W-1:0] run;
      logic             last;
   } job_type;

endpackage

@@ rtl/sjf_front.sv @@
// ----------------------------------------------------------------------------
// sjf_front
// Takes job transfers and buffers them in a short queue for the back end.
// ----------------------------------------------------------------------------
module sjf_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [15:0]             req_arrival_time,
   input  logic [15:0]             req_run_length,
   input  logic                    req_last_job,
   output logic                    q_valid,
   input  logic                    q_ready,
   output sjf_pkg::job_type        q_data
);

   sjf_pkg::job_type            fifo_ff [sjf_pkg::QDEPTH];
   logic [sjf_pkg::QPTR_W:0]    wr_ptr_ff, wr_ptr_in;
   logic [sjf_pkg::QPTR_W:0]    rd_ptr_ff, rd_ptr_in;
   logic                        push, pop, full, empty;

   assign empty = (wr_ptr_ff == rd_ptr_ff);
   assign full  = (wr_ptr_ff[sjf_pkg::QPTR_W] != rd_ptr_ff[sjf_pkg::QPTR_W]) &&
                  (wr_ptr_ff[sjf_pkg::QPTR_W-1:0] == rd_ptr_ff[sjf_pkg::QPTR_W-1:0]);

   assign req_ready = !full;
   assign q_valid   = !empty;
   assign q_data    = fifo_ff[rd_ptr_ff[sjf_pkg::QPTR_W-1:0]];
   assign push      = req_valid && !full;
   assign pop       = q_ready && !empty;
   assign wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff[sjf_pkg::QPTR_W-1:0]] <= '{arrival: req_arrival_time,
                                                      run:     req_run_length,
                                                      last:    req_last_job};
      end
   end

endmodule

@@ rtl/sjf_div.sv @@
// ----------------------------------------------------------------------------
// sjf_div
// Restoring divider, one quotient bit per cycle, for the mean turnaround.
// ----------------------------------------------------------------------------
module sjf_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [sjf_pkg::TOT_W-1:0] dividend,
   input  logic [sjf_pkg::CNT_W-1:0] divisor,
   output logic                      done,
   output logic [sjf_pkg::TOT_W-1:0] quotient
);

   localparam int STEP_W = $clog2(sjf_pkg::TOT_W + 1);

   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [STEP_W-1:0]         step_ff, step_in;
   logic [sjf_pkg::TOT_W-1:0] dvd_ff, dvd_in;
   logic [sjf_pkg::CNT_W-1:0] rem_ff, rem_in;
   logic [sjf_pkg::CNT_W-1:0] dsr_ff, dsr_in;
   logic [sjf_pkg::CNT_W:0]   trial;
   logic                      ge;

   assign trial = {rem_ff, dvd_ff[sjf_pkg::TOT_W-1]};
   assign ge    = (trial >= {1'b0, dsr_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         dvd_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         dvd_in  = {dvd_ff[sjf_pkg::TOT_W-2:0], ge};
         rem_in  = ge ? sjf_pkg::CNT_W'(trial - {1'b0, dsr_ff}) : trial[sjf_pkg::CNT_W-1:0];
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(sjf_pkg::TOT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule

@@ rtl/sjf_back.sv @@
// ----------------------------------------------------------------------------
// sjf_back
// Job store and scheduler: each pass over the store picks the next job to run.
// ----------------------------------------------------------------------------
module sjf_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       q_valid,
   output logic                       q_ready,
   input  sjf_pkg::job_type           q_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [sjf_pkg::MEAN_W-1:0] rsp_mean_turnaround
);

   typedef struct packed {
      logic                      done;
      logic [sjf_pkg::ARR_W-1:0] arrival;
      logic [sjf_pkg::RUN_W-1:0] run;
   } ent_type;

   typedef enum logic [1:0] {ST_LOAD, ST_SCAN, ST_DIV, ST_OUT} state_type;

   ent_type                     store_mem [sjf_pkg::MAX_JOBS];
   ent_type                     mem_q_ff;

   state_type                   state_ff, state_in;
   logic [sjf_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic [sjf_pkg::CNT_W-1:0]   left_ff, left_in;
   logic [sjf_pkg::CNT_W-1:0]   rd_idx_ff, rd_idx_in;
   logic                        pend_ff, pend_in;
   logic [sjf_pkg::IDX_W-1:0]   pidx_ff, pidx_in;
   logic [sjf_pkg::TIME_W-1:0]  now_ff, now_in;
   logic [sjf_pkg::TOT_W-1:0]   total_ff, total_in;
   logic                        has_e_ff, has_e_in;
   logic [sjf_pkg::RUN_W-1:0]   be_run_ff, be_run_in;
   logic [sjf_pkg::ARR_W-1:0]   be_arr_ff, be_arr_in;
   logic [sjf_pkg::IDX_W-1:0]   be_idx_ff, be_idx_in;
   logic                        has_m_ff, has_m_in;
   logic [sjf_pkg::RUN_W-1:0]   mn_run_ff, mn_run_in;
   logic [sjf_pkg::ARR_W-1:0]   mn_arr_ff, mn_arr_in;
   logic [sjf_pkg::IDX_W-1:0]   mn_idx_ff, mn_idx_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [sjf_pkg::MEAN_W-1:0]  rsp_mean_ff, rsp_mean_in;

   logic                        wr_en, rd_en;
   logic [sjf_pkg::IDX_W-1:0]   wr_addr;
   ent_type                     wr_data;
   logic                        div_start, div_done;
   logic [sjf_pkg::TOT_W-1:0]   div_quo;
   logic [sjf_pkg::TIME_W-1:0]  start_t, finish_t;
   logic [sjf_pkg::RUN_W-1:0]   sel_run;
   logic [sjf_pkg::ARR_W-1:0]   sel_arr;
   logic [sjf_pkg::IDX_W-1:0]   sel_idx;

   sjf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (total_in),
      .divisor  (cnt_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   // ready queue empty means jump the clock to the earliest waiting arrival
   assign sel_run  = has_e_ff ? be_run_ff : mn_run_ff;
   assign sel_arr  = has_e_ff ? be_arr_ff : mn_arr_ff;
   assign sel_idx  = has_e_ff ? be_idx_ff : mn_idx_ff;
   assign start_t  = has_e_ff ? now_ff : sjf_pkg::TIME_W'(mn_arr_ff);
   assign finish_t = start_t + sjf_pkg::TIME_W'(sel_run);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      left_in      = left_ff;
      rd_idx_in    = rd_idx_ff;
      pend_in      = pend_ff;
      pidx_in      = pidx_ff;
      now_in       = now_ff;
      total_in     = total_ff;
      has_e_in     = has_e_ff;
      be_run_in    = be_run_ff;
      be_arr_in    = be_arr_ff;
      be_idx_in    = be_idx_ff;
      has_m_in     = has_m_ff;
      mn_run_in    = mn_run_ff;
      mn_arr_in    = mn_arr_ff;
      mn_idx_in    = mn_idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_mean_in  = rsp_mean_ff;
      wr_en        = 1'b0;
      wr_addr      = cnt_ff[sjf_pkg::IDX_W-1:0];
      wr_data      = '{done: 1'b0, arrival: q_data.arrival, run: q_data.run};
      rd_en        = 1'b0;
      q_ready      = 1'b0;
      div_start    = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            q_ready = 1'b1;
            if (q_valid) begin
               // store full: job dropped, its last flag still counts
               if (cnt_ff < sjf_pkg::CNT_W'(sjf_pkg::MAX_JOBS)) begin
                  wr_en  = 1'b1;
                  cnt_in = cnt_ff + 1'b1;
               end
               if (q_data.last) begin
                  state_in  = ST_SCAN;
                  left_in   = cnt_in;
                  now_in    = '0;
                  total_in  = '0;
                  rd_idx_in = '0;
                  pend_in   = 1'b0;
                  has_e_in  = 1'b0;
                  has_m_in  = 1'b0;
               end
            end
         end
         ST_SCAN: begin
            pend_in = 1'b0;
            if (rd_idx_ff < cnt_ff) begin
               rd_en     = 1'b1;
               rd_idx_in = rd_idx_ff + 1'b1;
               pend_in   = 1'b1;
               pidx_in   = rd_idx_ff[sjf_pkg::IDX_W-1:0];
            end
            if (pend_ff && !mem_q_ff.done) begin
               if ((sjf_pkg::TIME_W'(mem_q_ff.arrival) <= now_ff) &&
                   (!has_e_ff || ({mem_q_ff.run, mem_q_ff.arrival} <
                                  {be_run_ff, be_arr_ff}))) begin
                  has_e_in  = 1'b1;
                  be_run_in = mem_q_ff.run;
                  be_arr_in = mem_q_ff.arrival;
                  be_idx_in = pidx_ff;
               end
               if (!has_m_ff || ({mem_q_ff.arrival, mem_q_ff.run} <
                                 {mn_arr_ff, mn_run_ff})) begin
                  has_m_in  = 1'b1;
                  mn_run_in = mem_q_ff.run;
                  mn_arr_in = mem_q_ff.arrival;
                  mn_idx_in = pidx_ff;
               end
            end
            if ((rd_idx_ff == cnt_ff) && !pend_ff) begin
               // end of pass: run the chosen job and retire it
               now_in    = finish_t;
               total_in  = total_ff + sjf_pkg::TOT_W'(finish_t - sjf_pkg::TIME_W'(sel_arr));
               wr_en     = 1'b1;
               wr_addr   = sel_idx;
               wr_data   = '{done: 1'b1, arrival: sel_arr, run: sel_run};
               left_in   = left_ff - 1'b1;
               rd_idx_in = '0;
               has_e_in  = 1'b0;
               has_m_in  = 1'b0;
               if (left_ff == sjf_pkg::CNT_W'(1)) begin
                  state_in  = ST_DIV;
                  div_start = 1'b1;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               rsp_mean_in  = div_quo[sjf_pkg::MEAN_W-1:0];
               rsp_valid_in = 1'b1;
               state_in     = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               cnt_in       = '0;
               state_in     = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         cnt_ff       <= '0;
         left_ff      <= '0;
         rd_idx_ff    <= '0;
         pend_ff      <= 1'b0;
         has_e_ff     <= 1'b0;
         has_m_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         left_ff      <= left_in;
         rd_idx_ff    <= rd_idx_in;
         pend_ff      <= pend_in;
         has_e_ff     <= has_e_in;
         has_m_ff     <= has_m_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pidx_ff     <= pidx_in;
      now_ff      <= now_in;
      total_ff    <= total_in;
      be_run_ff   <= be_run_in;
      be_arr_ff   <= be_arr_in;
      be_idx_ff   <= be_idx_in;
      mn_run_ff   <= mn_run_in;
      mn_arr_ff   <= mn_arr_in;
      mn_idx_ff   <= mn_idx_in;
      rsp_mean_ff <= rsp_mean_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         mem_q_ff <= store_mem[rd_idx_ff[sjf_pkg::IDX_W-1:0]];
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_mean_turnaround = rsp_mean_ff;

endmodule

@@ rtl/sjf_average_turnaround.sv @@
// ----------------------------------------------------------------------------
// sjf_average_turnaround
// Non-preemptive shortest-job-first scheduler giving the mean turnaround.
// ----------------------------------------------------------------------------
// channel   direction  signals
// req_      in         arrival_time[15:0], run_length[15:0], last_job
// rsp_      out        mean_turnaround[25:0], one per set on the last job
//
// jobs load one per cycle through a 4-entry queue into the store while loading
// after the last job: n passes over the store (one read port), each picking
// one job, then 35 division steps; the quotient goes to the result register
// no clearing pass after reset; synchronous active-high reset
// while a set is scheduled or a result waits, the queue takes up to four
// more jobs, then req_ready stays low until the store is loading again
// ----------------------------------------------------------------------------
module sjf_average_turnaround (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_arrival_time,
   input  logic [15:0] req_run_length,
   input  logic        req_last_job,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [25:0] rsp_mean_turnaround
);

   logic             q_valid;
   logic             q_ready;
   sjf_pkg::job_type q_data;

   sjf_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_arrival_time (req_arrival_time),
      .req_run_length   (req_run_length),
      .req_last_job     (req_last_job),
      .q_valid          (q_valid),
      .q_ready          (q_ready),
      .q_data           (q_data)
   );

   sjf_back u_back (
      .clock               (clock),
      .reset               (reset),
      .q_valid             (q_valid),
      .q_ready             (q_ready),
      .q_data              (q_data),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_mean_turnaround (rsp_mean_turnaround)
   );

endmodule
